// File: design/rcyl_pkg.sv
// Package for the unit cylinder intersection block.
// Shared widths, default parameter values, register indexes and flag types.
// No dependencies.
package rcyl_pkg;

    // Coordinate and distance width (signed fixed point)
    localparam int T_W      = 32;
    localparam int P_W      = 2 * T_W;
    localparam int CNT_W    = 3;
    localparam int MAX_HITS = 4;
    localparam int SLOT_W   = 2;

    // Default fixed-point format and near-zero threshold
    localparam int FRAC_BITS_DEF     = 16;
    localparam int NEAR_ZERO_EPS_DEF = 1;

    // Square root width and divider latency
    localparam int ROOT_W  = P_W;
    localparam int DIV_LAT = T_W + 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_Y  = 2'd0,
        CFG_MAX_Y  = 2'd1,
        CFG_CAPPED = 2'd2
    } cfg_idx_t;

    // Per-ray decision flags carried down the pipeline
    typedef struct packed {
        logic near_a;
        logic disc_neg;
        logic dy_near;
    } hit_flags_t;

endpackage

// File: design/rcyl_if.sv
// Channel interfaces of the unit cylinder intersection block.
// Ray input, hit output and configuration write channels; uses rcyl_pkg.

interface rcyl_ray_if import rcyl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [T_W-1:0] origin_x;
    logic signed [T_W-1:0] origin_y;
    logic signed [T_W-1:0] origin_z;
    logic signed [T_W-1:0] dir_x;
    logic signed [T_W-1:0] dir_y;
    logic signed [T_W-1:0] dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface rcyl_hit_if import rcyl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CNT_W-1:0]      hit_count;
    logic signed [T_W-1:0] hit_t0;
    logic signed [T_W-1:0] hit_t1;
    logic signed [T_W-1:0] hit_t2;
    logic signed [T_W-1:0] hit_t3;

    modport source (output valid, hit_count, hit_t0, hit_t1, hit_t2, hit_t3,
                    input ready);
    modport sink   (input valid, hit_count, hit_t0, hit_t1, hit_t2, hit_t3,
                    output ready);
endinterface

interface rcyl_cfg_if import rcyl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [T_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/rcyl_delay.sv
// Enabled shift line that keeps side data aligned with the arithmetic units.
// Uses rcyl_pkg only for house consistency of the import.
module rcyl_delay import rcyl_pkg::*; #(
    parameter int DEPTH = 1,
    parameter int W     = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [DEPTH];

    // Shift when the pipeline advances
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// File: design/rcyl_mul64.sv
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on rcyl_pkg for widths.
module rcyl_mul64 import rcyl_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [P_W-1:0]   a,
    input  logic [P_W-1:0]   b,
    output logic [2*P_W-1:0] p
);

    logic [P_W-1:0]   pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [2*P_W-1:0] p_reg;

    // Stage 1: partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= P_W'(a[T_W-1:0])   * P_W'(b[T_W-1:0]);
            pp_lh_reg <= P_W'(a[T_W-1:0])   * P_W'(b[P_W-1:T_W]);
            pp_hl_reg <= P_W'(a[P_W-1:T_W]) * P_W'(b[T_W-1:0]);
            pp_hh_reg <= P_W'(a[P_W-1:T_W]) * P_W'(b[P_W-1:T_W]);
        end
    end

    // Stage 2: weighted sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= {pp_hh_reg, pp_ll_reg}
                   + ((2*P_W)'(pp_lh_reg) << T_W)
                   + ((2*P_W)'(pp_hl_reg) << T_W);
        end
    end

    assign p = p_reg;

endmodule

// File: design/rcyl_isqrt.sv
// Pipelined integer square root, one result bit per stage, rounding down.
// Depends on rcyl_pkg.
module rcyl_isqrt import rcyl_pkg::*; #(
    parameter int RW = ROOT_W
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] v,
    output logic [RW-1:0]   root
);

    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] v_reg    [RW];

    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        logic [RW+1:0]   rem_prev;
        logic [RW-1:0]   root_prev;
        logic [2*RW-1:0] v_prev;
        logic [RW+3:0]   rsh;
        logic [RW+3:0]   trial;
        logic            ge;

        if (s == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign v_prev    = v;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[s-1];
            assign root_prev = root_reg[s-1];
            assign v_prev    = v_reg[s-1];
        end

        // Bring down the next bit pair, try root*4+1
        assign rsh   = {rem_prev, v_prev[2*RW-1-2*s -: 2]};
        assign trial = {2'b00, root_prev, 2'b01};
        assign ge    = (rsh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? (RW+2)'(rsh - trial) : (RW+2)'(rsh);
                root_reg[s] <= {root_prev[RW-2:0], ge};
                v_reg[s]    <= v_prev;
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

// File: design/rcyl_div.sv
// Pipelined signed fixed-point divider: num * 2^FRAC_BITS / den, toward zero,
// saturated to T_W bits. Restoring, one quotient bit per stage. Uses rcyl_pkg.
module rcyl_div import rcyl_pkg::*; #(
    parameter int NUM_W     = 67,
    parameter int DEN_W     = 64,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic signed [T_W-1:0]   quo
);

    localparam int MW = NUM_W + FRAC_BITS;
    localparam int HW = MW - T_W;
    localparam int CW = (HW > DEN_W) ? HW : DEN_W;

    logic [NUM_W-1:0] mag;
    logic [MW-1:0]    m;
    logic [HW-1:0]    hi;

    logic             p_neg_reg, p_ovf_reg;
    logic [DEN_W-1:0] p_rem_reg, p_den_reg;
    logic [T_W-1:0]   p_lo_reg;

    logic             st_neg_reg [T_W];
    logic             st_ovf_reg [T_W];
    logic [DEN_W-1:0] st_rem_reg [T_W];
    logic [DEN_W-1:0] st_den_reg [T_W];
    logic [T_W-1:0]   st_lo_reg  [T_W];
    logic [T_W-1:0]   st_q_reg   [T_W];

    logic [T_W-1:0]        limit, sat;
    logic signed [T_W-1:0] quo_reg;

    // Prep: magnitude, scale, overflow when quotient would exceed T_W bits
    assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign m   = {mag, {FRAC_BITS{1'b0}}};
    assign hi  = m[MW-1:T_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_neg_reg <= num[NUM_W-1];
            p_ovf_reg <= (CW'(hi) >= CW'(den));
            p_rem_reg <= DEN_W'(hi);
            p_den_reg <= den;
            p_lo_reg  <= m[T_W-1:0];
        end
    end

    for (genvar j = 0; j < T_W; j++)
    begin : g_step
        logic             neg_prev, ovf_prev;
        logic [DEN_W-1:0] rem_prev, den_prev;
        logic [T_W-1:0]   lo_prev, q_prev, q_next;
        logic [DEN_W:0]   rsh;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign neg_prev = p_neg_reg;
            assign ovf_prev = p_ovf_reg;
            assign rem_prev = p_rem_reg;
            assign den_prev = p_den_reg;
            assign lo_prev  = p_lo_reg;
            assign q_prev   = '0;
        end
        else
        begin : g_next
            assign neg_prev = st_neg_reg[j-1];
            assign ovf_prev = st_ovf_reg[j-1];
            assign rem_prev = st_rem_reg[j-1];
            assign den_prev = st_den_reg[j-1];
            assign lo_prev  = st_lo_reg[j-1];
            assign q_prev   = st_q_reg[j-1];
        end

        // Shift in next dividend bit, subtract when it fits
        assign rsh = {rem_prev, lo_prev[T_W-1-j]};
        assign ge  = (rsh >= {1'b0, den_prev});

        always_comb
        begin
            q_next = q_prev;
            q_next[T_W-1-j] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_neg_reg[j] <= neg_prev;
                st_ovf_reg[j] <= ovf_prev;
                st_rem_reg[j] <= ge ? DEN_W'(rsh - {1'b0, den_prev}) : DEN_W'(rsh);
                st_den_reg[j] <= den_prev;
                st_lo_reg[j]  <= lo_prev;
                st_q_reg[j]   <= q_next;
            end
        end
    end

    // Saturate and apply sign
    assign limit = st_neg_reg[T_W-1] ? {1'b1, {(T_W-1){1'b0}}} : {1'b0, {(T_W-1){1'b1}}};
    assign sat   = (st_ovf_reg[T_W-1] || (st_q_reg[T_W-1] > limit)) ? limit : st_q_reg[T_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= st_neg_reg[T_W-1] ? $signed(T_W'(-sat)) : $signed(sat);
        end
    end

    assign quo = quo_reg;

endmodule

// File: design/ray_unit_cylinder_intersect.sv
// Ray against unit-radius cylinder along y, capped or open, bounded in height.
// Depends on rcyl_pkg, the channel interfaces, rcyl_mul64, rcyl_isqrt,
// rcyl_div and rcyl_delay.
//
// Usage:
//   ray : one transaction per ray (origin and direction, signed fixed point).
//   hit : one transaction per ray: hit_count (0..4) and four distances; found ones are
//         packed to the front in the order side root near, side root far, cap at
//         min_y, cap at max_y; unused distances read 0.
//   cfg : index 0 = min_y, 1 = max_y, 2 = capped; always ready, write while idle.
// Throughput: one ray per cycle while the hit receiver takes results.
// Depth: the pipeline depth is set mainly by the 64-stage square root and
//   the 34-stage dividers.
// Stall: when a result waits untaken, the whole pipeline holds and ray.ready
//   drops in the same cycle; nothing is lost or repeated.
// Reset: pipeline empties, registers return to min_y = most negative,
//   max_y = most positive, capped = 0.
module ray_unit_cylinder_intersect import rcyl_pkg::*; #(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int NEAR_ZERO_EPS = NEAR_ZERO_EPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rcyl_ray_if.sink    ray,
    rcyl_hit_if.source  hit,
    rcyl_cfg_if.sink    cfg
);

    localparam int H_W   = P_W + 1;
    localparam int N_W   = P_W + 3;
    localparam int B_W   = T_W + 1;
    localparam int X_W   = P_W + 1;
    localparam int XM_W  = 2 * FRAC_BITS + 1;
    localparam int SQ_W  = 2 * XM_W;
    localparam int LAT   = 4 + 1 + ROOT_W + 1 + DIV_LAT + 4;
    localparam logic signed [H_W-1:0] ONE_SQ = H_W'(1) << (2 * FRAC_BITS);

    typedef struct packed {
        logic signed [H_W-1:0] h;
        logic [P_W-1:0]        a;
        logic signed [T_W-1:0] ox, oy, oz, dx, dy, dz;
        logic                  near_a;
    } side_a_t;

    typedef struct packed {
        hit_flags_t            flags;
        logic signed [T_W-1:0] ox, oy, oz, dx, dy, dz;
    } side_b_t;

    function automatic logic [X_W-1:0] absx(input logic signed [X_W-1:0] v);
        absx = v[X_W-1] ? X_W'(-v) : X_W'(v);
    endfunction

    // ---------------- control ----------------
    logic              en;
    logic [LAT-1:0]    vld_reg;

    assign en        = !vld_reg[LAT-1] || hit.ready;
    assign ray.ready = en;
    assign hit.valid = vld_reg[LAT-1];
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], ray.valid};
        end
    end

    // ---------------- configuration registers ----------------
    logic signed [T_W-1:0] cfg_min_reg, cfg_max_reg;
    logic                  cfg_cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_min_reg <= {1'b1, {(T_W-1){1'b0}}};
            cfg_max_reg <= {1'b0, {(T_W-1){1'b1}}};
            cfg_cap_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MIN_Y:  cfg_min_reg <= $signed(cfg.data);
                CFG_MAX_Y:  cfg_max_reg <= $signed(cfg.data);
                CFG_CAPPED: cfg_cap_reg <= cfg.data[0];
                default:    ;
            endcase
        end
    end

    // ---------------- S1: input products ----------------
    logic signed [P_W-1:0] s1_dxdx, s1_dzdz, s1_oxdx, s1_ozdz, s1_oxox, s1_ozoz;
    logic signed [T_W-1:0] s1_ox, s1_oy, s1_oz, s1_dx, s1_dy, s1_dz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dxdx <= P_W'(ray.dir_x) * P_W'(ray.dir_x);
            s1_dzdz <= P_W'(ray.dir_z) * P_W'(ray.dir_z);
            s1_oxdx <= P_W'(ray.origin_x) * P_W'(ray.dir_x);
            s1_ozdz <= P_W'(ray.origin_z) * P_W'(ray.dir_z);
            s1_oxox <= P_W'(ray.origin_x) * P_W'(ray.origin_x);
            s1_ozoz <= P_W'(ray.origin_z) * P_W'(ray.origin_z);
            s1_ox   <= ray.origin_x;
            s1_oy   <= ray.origin_y;
            s1_oz   <= ray.origin_z;
            s1_dx   <= ray.dir_x;
            s1_dy   <= ray.dir_y;
            s1_dz   <= ray.dir_z;
        end
    end

    // ---------------- S2: quadratic coefficients ----------------
    logic [P_W-1:0]        a_c;
    logic signed [H_W-1:0] h_c, c_c;
    logic [P_W-1:0]        s2_hm, s2_cm;
    logic                  s2_cneg;
    side_a_t               s2_side;

    assign a_c = P_W'(unsigned'(s1_dxdx)) + P_W'(unsigned'(s1_dzdz));
    assign h_c = H_W'(s1_oxdx) + H_W'(s1_ozdz);
    assign c_c = H_W'(s1_oxox) + H_W'(s1_ozoz) - ONE_SQ;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_hm          <= h_c[H_W-1] ? P_W'(-h_c) : P_W'(h_c);
            s2_cm          <= c_c[H_W-1] ? P_W'(-c_c) : P_W'(c_c);
            s2_cneg        <= c_c[H_W-1];
            s2_side.h      <= h_c;
            s2_side.a      <= a_c;
            s2_side.ox     <= s1_ox;
            s2_side.oy     <= s1_oy;
            s2_side.oz     <= s1_oz;
            s2_side.dx     <= s1_dx;
            s2_side.dy     <= s1_dy;
            s2_side.dz     <= s1_dz;
            s2_side.near_a <= ((a_c >> FRAC_BITS) <= P_W'(NEAR_ZERO_EPS));
        end
    end

    // ---------------- S3-S4: h*h and a*|c| ----------------
    logic [2*P_W-1:0] hh, ac;
    logic             s3_cneg, s4_cneg;

    rcyl_mul64 u_mul_hh (.clk(clk), .en(en), .a(s2_hm),     .b(s2_hm), .p(hh));
    rcyl_mul64 u_mul_ac (.clk(clk), .en(en), .a(s2_side.a), .b(s2_cm), .p(ac));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_cneg <= s2_cneg;
            s4_cneg <= s3_cneg;
        end
    end

    // ---------------- S5: discriminant ----------------
    logic [2*P_W:0]   disc_c;
    logic [2*P_W-1:0] s5_disc;
    logic             s5_dneg;

    assign disc_c = s4_cneg ? ({1'b0, hh} + {1'b0, ac}) : ({1'b0, hh} - {1'b0, ac});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_disc <= disc_c[2*P_W-1:0];
            s5_dneg <= disc_c[2*P_W];
        end
    end

    // ---------------- S6-S69: square root ----------------
    logic [ROOT_W-1:0] sq_root;
    side_a_t           sa_out;
    logic              dneg_69;

    rcyl_isqrt #(.RW(ROOT_W)) u_isqrt (.clk(clk), .en(en), .v(s5_disc), .root(sq_root));

    rcyl_delay #(.DEPTH(3 + ROOT_W), .W($bits(side_a_t))) u_dly_a (
        .clk(clk), .en(en), .din(s2_side), .dout(sa_out)
    );

    rcyl_delay #(.DEPTH(ROOT_W), .W(1)) u_dly_dneg (
        .clk(clk), .en(en), .din(s5_dneg), .dout(dneg_69)
    );

    // ---------------- S70: numerators and denominators ----------------
    logic signed [N_W-1:0] h_e, root_e;
    logic [T_W-1:0]        dya_c;
    logic signed [N_W-1:0] s70_n0, s70_n1;
    logic signed [B_W-1:0] s70_b0, s70_b1;
    logic [P_W-1:0]        s70_a;
    logic [T_W-1:0]        s70_dya;
    side_b_t               s70_side;

    assign h_e    = N_W'(sa_out.h);
    assign root_e = $signed(N_W'(sq_root));
    assign dya_c  = sa_out.dy[T_W-1] ? T_W'(-sa_out.dy) : T_W'(sa_out.dy);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s70_n0                  <= -h_e - root_e;
            s70_n1                  <= -h_e + root_e;
            s70_b0                  <= B_W'(cfg_min_reg) - B_W'(sa_out.oy);
            s70_b1                  <= B_W'(cfg_max_reg) - B_W'(sa_out.oy);
            s70_a                   <= sa_out.a;
            s70_dya                 <= dya_c;
            s70_side.flags.near_a   <= sa_out.near_a;
            s70_side.flags.disc_neg <= dneg_69;
            s70_side.flags.dy_near  <= (dya_c <= T_W'(NEAR_ZERO_EPS));
            s70_side.ox             <= sa_out.ox;
            s70_side.oy             <= sa_out.oy;
            s70_side.oz             <= sa_out.oz;
            s70_side.dx             <= sa_out.dx;
            s70_side.dy             <= sa_out.dy;
            s70_side.dz             <= sa_out.dz;
        end
    end

    // ---------------- S71-S104: distance dividers ----------------
    logic signed [T_W-1:0] q_r0, q_r1, q_c0, q_c1;
    side_b_t               sb_out;
    logic signed [B_W-1:0] b0_s, b1_s;
    logic signed [T_W-1:0] dy_s;

    assign b0_s = s70_side.flags.dy_near ? B_W'(0) : s70_b0;
    assign b1_s = s70_side.flags.dy_near ? B_W'(0) : s70_b1;
    assign dy_s = s70_side.dy;

    rcyl_div #(.NUM_W(N_W), .DEN_W(P_W), .FRAC_BITS(FRAC_BITS)) u_div_r0 (
        .clk(clk), .en(en), .num(s70_n0), .den(s70_a), .quo(q_r0)
    );
    rcyl_div #(.NUM_W(N_W), .DEN_W(P_W), .FRAC_BITS(FRAC_BITS)) u_div_r1 (
        .clk(clk), .en(en), .num(s70_n1), .den(s70_a), .quo(q_r1)
    );
    // Cap distances share the sign rule: negate numerator for negative dir_y
    rcyl_div #(.NUM_W(B_W + 1), .DEN_W(T_W), .FRAC_BITS(FRAC_BITS)) u_div_c0 (
        .clk(clk), .en(en),
        .num(dy_s[T_W-1] ? -(B_W+1)'(b0_s) : (B_W+1)'(b0_s)),
        .den(s70_dya), .quo(q_c0)
    );
    rcyl_div #(.NUM_W(B_W + 1), .DEN_W(T_W), .FRAC_BITS(FRAC_BITS)) u_div_c1 (
        .clk(clk), .en(en),
        .num(dy_s[T_W-1] ? -(B_W+1)'(b1_s) : (B_W+1)'(b1_s)),
        .den(s70_dya), .quo(q_c1)
    );

    rcyl_delay #(.DEPTH(DIV_LAT), .W($bits(side_b_t))) u_dly_b (
        .clk(clk), .en(en), .din(s70_side), .dout(sb_out)
    );

    // ---------------- S105: hit point products ----------------
    logic signed [P_W-1:0] s105_pr0, s105_pr1, s105_p0x, s105_p0z, s105_p1x, s105_p1z;
    logic signed [T_W-1:0] s105_r0, s105_r1, s105_c0, s105_c1;
    logic signed [T_W-1:0] s105_ox, s105_oy, s105_oz;
    hit_flags_t            s105_flags;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s105_pr0   <= P_W'(q_r0) * P_W'(sb_out.dy);
            s105_pr1   <= P_W'(q_r1) * P_W'(sb_out.dy);
            s105_p0x   <= P_W'(q_c0) * P_W'(sb_out.dx);
            s105_p0z   <= P_W'(q_c0) * P_W'(sb_out.dz);
            s105_p1x   <= P_W'(q_c1) * P_W'(sb_out.dx);
            s105_p1z   <= P_W'(q_c1) * P_W'(sb_out.dz);
            s105_r0    <= q_r0;
            s105_r1    <= q_r1;
            s105_c0    <= q_c0;
            s105_c1    <= q_c1;
            s105_ox    <= sb_out.ox;
            s105_oy    <= sb_out.oy;
            s105_oz    <= sb_out.oz;
            s105_flags <= sb_out.flags;
        end
    end

    // ---------------- S106: height test, cap hit points ----------------
    logic signed [X_W-1:0] y0_c, y1_c, lo_b, hi_b, x0_c, z0_c, x1_c, z1_c;
    logic [X_W-1:0]        x0_a, z0_a, x1_a, z1_a, cap_lim;
    logic signed [T_W-1:0] s106_r0, s106_r1, s106_c0, s106_c1;
    hit_flags_t            s106_flags;
    logic                  s106_in0, s106_in1;
    logic                  s106_fx0, s106_fz0, s106_fx1, s106_fz1;
    logic [XM_W-1:0]       s106_x0, s106_z0, s106_x1, s106_z1;

    assign y0_c    = (X_W'(s105_oy) <<< FRAC_BITS) + X_W'(s105_pr0);
    assign y1_c    = (X_W'(s105_oy) <<< FRAC_BITS) + X_W'(s105_pr1);
    assign lo_b    = X_W'(cfg_min_reg) <<< FRAC_BITS;
    assign hi_b    = X_W'(cfg_max_reg) <<< FRAC_BITS;
    assign x0_c    = (X_W'(s105_ox) <<< FRAC_BITS) + X_W'(s105_p0x);
    assign z0_c    = (X_W'(s105_oz) <<< FRAC_BITS) + X_W'(s105_p0z);
    assign x1_c    = (X_W'(s105_ox) <<< FRAC_BITS) + X_W'(s105_p1x);
    assign z1_c    = (X_W'(s105_oz) <<< FRAC_BITS) + X_W'(s105_p1z);
    assign x0_a    = absx(x0_c);
    assign z0_a    = absx(z0_c);
    assign x1_a    = absx(x1_c);
    assign z1_a    = absx(z1_c);
    assign cap_lim = X_W'(1) << (2 * FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s106_r0    <= s105_r0;
            s106_r1    <= s105_r1;
            s106_c0    <= s105_c0;
            s106_c1    <= s105_c1;
            s106_flags <= s105_flags;
            s106_in0   <= (y0_c > lo_b) && (y0_c < hi_b);
            s106_in1   <= (y1_c > lo_b) && (y1_c < hi_b);
            s106_fx0   <= (x0_a <= cap_lim);
            s106_fz0   <= (z0_a <= cap_lim);
            s106_fx1   <= (x1_a <= cap_lim);
            s106_fz1   <= (z1_a <= cap_lim);
            s106_x0    <= XM_W'(x0_a);
            s106_z0    <= XM_W'(z0_a);
            s106_x1    <= XM_W'(x1_a);
            s106_z1    <= XM_W'(z1_a);
        end
    end

    // ---------------- S107: cap radius squares ----------------
    logic signed [T_W-1:0] s107_r0, s107_r1, s107_c0, s107_c1;
    hit_flags_t            s107_flags;
    logic                  s107_in0, s107_in1, s107_f0, s107_f1;
    logic [SQ_W-1:0]       s107_x0, s107_z0, s107_x1, s107_z1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s107_r0    <= s106_r0;
            s107_r1    <= s106_r1;
            s107_c0    <= s106_c0;
            s107_c1    <= s106_c1;
            s107_flags <= s106_flags;
            s107_in0   <= s106_in0;
            s107_in1   <= s106_in1;
            s107_f0    <= s106_fx0 && s106_fz0;
            s107_f1    <= s106_fx1 && s106_fz1;
            s107_x0    <= SQ_W'(s106_x0) * SQ_W'(s106_x0);
            s107_z0    <= SQ_W'(s106_z0) * SQ_W'(s106_z0);
            s107_x1    <= SQ_W'(s106_x1) * SQ_W'(s106_x1);
            s107_z1    <= SQ_W'(s106_z1) * SQ_W'(s106_z1);
        end
    end

    // ---------------- S108: hit selection and output register ----------------
    logic [SQ_W:0]         r2_0, r2_1, unit_r2;
    logic                  side_en, cap_en;
    logic [MAX_HITS-1:0]   cand_v;
    logic signed [T_W-1:0] cand_t [MAX_HITS];
    logic signed [T_W-1:0] slot   [MAX_HITS];
    logic [CNT_W-1:0]      n_c;

    logic [CNT_W-1:0]      cnt_reg;
    logic signed [T_W-1:0] t_reg [MAX_HITS];

    assign r2_0    = {1'b0, s107_x0} + {1'b0, s107_z0};
    assign r2_1    = {1'b0, s107_x1} + {1'b0, s107_z1};
    assign unit_r2 = (SQ_W+1)'(1) << (4 * FRAC_BITS);
    assign side_en = !s107_flags.near_a && !s107_flags.disc_neg;
    assign cap_en  = (s107_flags.near_a || !s107_flags.disc_neg) && cfg_cap_reg
                     && !s107_flags.dy_near;

    assign cand_v[0] = side_en && s107_in0;
    assign cand_v[1] = side_en && s107_in1;
    assign cand_v[2] = cap_en && s107_f0 && (r2_0 <= unit_r2);
    assign cand_v[3] = cap_en && s107_f1 && (r2_1 <= unit_r2);
    assign cand_t[0] = s107_r0;
    assign cand_t[1] = s107_r1;
    assign cand_t[2] = s107_c0;
    assign cand_t[3] = s107_c1;

    // Pack found distances to the front, zeros behind
    always_comb
    begin
        n_c = '0;
        for (int k = 0; k < MAX_HITS; k++)
        begin
            slot[k] = '0;
        end
        for (int k = 0; k < MAX_HITS; k++)
        begin
            if (cand_v[k])
            begin
                slot[n_c[SLOT_W-1:0]] = cand_t[k];
                n_c = n_c + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnt_reg <= n_c;
            for (int k = 0; k < MAX_HITS; k++)
            begin
                t_reg[k] <= slot[k];
            end
        end
    end

    assign hit.hit_count = cnt_reg;
    assign hit.hit_t0    = t_reg[0];
    assign hit.hit_t1    = t_reg[1];
    assign hit.hit_t2    = t_reg[2];
    assign hit.hit_t3    = t_reg[3];

endmodule

// File: design/rcyl_checker.sv
// Port-level checks for the unit cylinder intersection block, with bind.
// Depends on rcyl_pkg and ray_unit_cylinder_intersect.
module rcyl_checker import rcyl_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  ray_ready,
    input logic                  hit_valid,
    input logic                  hit_ready,
    input logic [CNT_W-1:0]      hit_count,
    input logic signed [T_W-1:0] hit_t0,
    input logic signed [T_W-1:0] hit_t1,
    input logic signed [T_W-1:0] hit_t2,
    input logic signed [T_W-1:0] hit_t3
);

    // Never more than four hits
    assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid |-> (hit_count <= CNT_W'(MAX_HITS)))
        else $error("hit_count above four");

    // Slots past the count read zero
    assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid |-> ((hit_count > 3'd0) || (hit_t0 == '0))
                   && ((hit_count > 3'd1) || (hit_t1 == '0))
                   && ((hit_count > 3'd2) || (hit_t2 == '0))
                   && ((hit_count > 3'd3) || (hit_t3 == '0)))
        else $error("unused hit distance not zero");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (hit_valid && !hit_ready) |=> (hit_valid && $stable(hit_count)
            && $stable(hit_t0) && $stable(hit_t1) && $stable(hit_t2) && $stable(hit_t3)))
        else $error("stalled hit transaction changed");

    // A stalled result freezes the pipeline input
    assert property (@(posedge clk) disable iff (!rst_n)
        (hit_valid && !hit_ready) |-> !ray_ready)
        else $error("ray accepted while output stalled");

endmodule

bind ray_unit_cylinder_intersect rcyl_checker u_rcyl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray_ready (ray.ready),
    .hit_valid (hit.valid),
    .hit_ready (hit.ready),
    .hit_count (hit.hit_count),
    .hit_t0    (hit.hit_t0),
    .hit_t1    (hit.hit_t1),
    .hit_t2    (hit.hit_t2),
    .hit_t3    (hit.hit_t3)
);
